// ===== rtl/core/rrm_pkg.sv =====
// Shared widths, register indexes and correction tables of the resistance meter.
`timescale 1ns / 1ps
package rrm_pkg;

	// field and datapath widths
	localparam int SAMPLE_W   = 12;
	localparam int REF_W      = 20;
	localparam int FULL_W     = 12;
	localparam int MEAN_W     = 12;
	localparam int RES_W      = 17;
	localparam int BAND_W     = 3;
	localparam int SUM_W      = 21;
	localparam int NUM_W      = REF_W + SUM_W;   // ref * sum
	localparam int MPLR_W     = SUM_W;           // serial multiplier operand
	localparam int PROD_W     = 48;              // ref * sum * percent fits here
	localparam int DIVIDEND_W = PROD_W;
	localparam int DIVISOR_W  = 28;              // denominator * 100 fits here
	localparam int MUL_CNT_W  = $clog2(MPLR_W);
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_OHMS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_CODE = 2'd1;
	localparam logic [REF_W-1:0]  REF_RESET  = 20'd47000;
	localparam logic [FULL_W-1:0] FULL_RESET = 12'd4095;

	// accepted raw range in ohms, and largest corrected value
	localparam logic [RES_W-1:0] RAW_LOW  = 17'd485;
	localparam logic [RES_W-1:0] RAW_HIGH = 17'd105000;
	localparam logic [RES_W-1:0] RES_MAX  = 17'd115500;

	// lower edge of bands 1..6
	localparam int BAND_COUNT = 6;
	localparam logic [RES_W-1:0] BAND_LIMIT [BAND_COUNT] =
		'{17'd800, 17'd900, 17'd1500, 17'd2500, 17'd8000, 17'd50000};

	// percent correction for each band
	function automatic logic [6:0] band_pct(input logic [BAND_W-1:0] b);
		logic [6:0] p;
		case (b)
			3'd0: p = 7'd70;
			3'd1: p = 7'd75;
			3'd2: p = 7'd82;
			3'd3: p = 7'd88;
			3'd4: p = 7'd93;
			3'd5: p = 7'd102;
			default: p = 7'd110;
		endcase
		return p;
	endfunction

	// operand bundles for the serial units
	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  mcand;
		logic [MPLR_W-1:0] mplr;
	} mul_req_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

endpackage

// ===== rtl/core/rrm_if.sv =====
// Channel interfaces of the resistance meter: samples, readings and configuration writes.
`timescale 1ns / 1ps

interface rrm_sample_if
	import rrm_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface rrm_reading_if
	import rrm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [MEAN_W-1:0] mean_code;
	logic [RES_W-1:0]  resistance_ohms;
	logic              out_of_range;
	logic [BAND_W-1:0] band;

	modport source (output valid, output mean_code, output resistance_ohms,
		output out_of_range, output band, input ready);
	modport sink   (input valid, input mean_code, input resistance_ohms,
		input out_of_range, input band, output ready);
endinterface

interface rrm_cfg_if
	import rrm_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ratiometric_resistance_meter_top.sv =====
// Top level of the ratiometric resistance meter: accumulator, reading sequencer, output register.
`timescale 1ns / 1ps
// Usage
//   samples  : one ADC code per item. Items that do not close a window are taken every
//              cycle. The item that closes a window of SAMPLES_PER_READING samples is
//              taken only while the reading engine is free.
//   readings : one item per closed window: rounded mean, corrected resistance, range
//              flag and correction band. Held in an output register until taken.
//   cfg      : register writes, always ready; index 0 reference ohms, 1 full-scale code.
// Sequence: the serial units, a 21-step shift-add multiplier and a 48-step restoring
//   divider, are used in turn for ref*sum, the raw quotient, the percent correction and
//   the mean. A raw value out of range skips the percent correction, and a denominator
//   that is not positive also skips the raw quotient.
// Throughput: one sample per cycle inside a window; the next window may fill while the
//   engine works, and its closing sample waits if the engine is still busy.
// Reset: clears the running sum and count, the held resistance, the engine and the output
//   register; the registers return to 47000 ohms and full scale 4095.
// Stall: if readings are not taken, the engine holds its result, and the closing sample
//   of the following window is refused until the output register frees.
module ratiometric_resistance_meter_top
	import rrm_pkg::*;
#(
	parameter int SAMPLES_PER_READING = 500,
	parameter int SAMPLE_BITS         = 12
) (
	input  logic   clk,
	input  logic   arst_n,
	rrm_sample_if.sink    samples,
	rrm_reading_if.source readings,
	rrm_cfg_if.sink       cfg
);

	localparam int CNT_W    = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
	localparam int USED_W   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [CNT_W-1:0]      LAST_CNT    = CNT_W'(SAMPLES_PER_READING - 1);
	localparam logic [SAMPLE_W-1:0]   SAMPLE_MASK = SAMPLE_W'((64'd1 << USED_W) - 64'd1);
	localparam logic [SUM_W:0]        SPR_V       = (SUM_W + 1)'(SAMPLES_PER_READING);
	localparam logic [DIVISOR_W-1:0]  MEAN_DIV    = DIVISOR_W'(2 * SAMPLES_PER_READING);
	localparam logic [DIVIDEND_W-1:0] MEAN_BIAS   = DIVIDEND_W'(SAMPLES_PER_READING);

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_MUL_NUM, S_DIV_RAW, S_BAND,
		S_MUL_PCT, S_DIV_COR, S_DIV_MEAN, S_OUT
	} state_t;

	// configuration registers
	logic [REF_W-1:0]  ref_q;
	logic [FULL_W-1:0] full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= REF_RESET;
			full_q <= FULL_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_REFERENCE_OHMS:  ref_q  <= cfg.data[REF_W-1:0];
				REG_FULL_SCALE_CODE: full_q <= cfg.data[FULL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// window accumulator
	state_t            state_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  win_sum_q;
	logic [SUM_W-1:0]  sum_next;
	logic              last_smp;
	logic              take;

	assign last_smp      = cnt_q == LAST_CNT;
	assign samples.ready = !last_smp || (state_q == S_IDLE);
	assign take          = samples.valid && samples.ready;
	assign sum_next      = sum_q + SUM_W'(samples.sample & SAMPLE_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (last_smp) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_smp)
			win_sum_q <= sum_next;
	end

	// serial arithmetic units
	mul_req_t              mul_req;
	div_req_t              div_req;
	logic                  mul_busy;
	logic                  div_busy;
	logic [PROD_W-1:0]     mul_prod;
	logic [DIVIDEND_W-1:0] div_quo;
	logic [DIVISOR_W-1:0]  div_rem;

	rrm_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.busy    (mul_busy),
		.product (mul_prod)
	);

	rrm_serial_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// sequencer datapath terms
	logic [SUM_W-1:0]     den_q;
	logic                 oor_q;
	logic [BAND_W-1:0]    band_q;
	logic [RES_W-1:0]     held_q;
	logic [MEAN_W-1:0]    mean_q;
	logic [SUM_W-1:0]     scale_c;
	logic                 den_bad_c;
	logic [DIVISOR_W-1:0] den100_c;
	logic                 raw_oor_c;
	logic [BAND_W-1:0]    band_c;
	logic                 out_free;

	// N * full scale never exceeds the sum width
	assign scale_c   = SUM_W'({{(SUM_W + 1 - FULL_W){1'b0}}, full_q} * SPR_V);
	assign den_bad_c = scale_c <= win_sum_q;
	assign den100_c  = DIVISOR_W'({{(DIVISOR_W - SUM_W){1'b0}}, den_q} * DIVISOR_W'(100));

	// exact range test on quotient and remainder of ref*sum / den
	assign raw_oor_c = (div_quo < DIVIDEND_W'(RAW_LOW)) || (div_quo > DIVIDEND_W'(RAW_HIGH))
		|| ((div_quo == DIVIDEND_W'(RAW_HIGH)) && (div_rem != '0));

	// band is the number of band edges at or below the raw value
	always_comb begin
		band_c = '0;
		for (int i = 0; i < BAND_COUNT; i++) begin
			if (div_quo >= DIVIDEND_W'(BAND_LIMIT[i]))
				band_c = band_c + 1'b1;
		end
	end

	assign out_free = !readings.valid || readings.ready;

	// unit requests for each step
	always_comb begin
		mul_req = '0;
		div_req = '0;
		case (state_q)
			S_PREP: begin
				mul_req.start = 1'b1;
				mul_req.mcand = NUM_W'(ref_q);
				mul_req.mplr  = win_sum_q;
			end
			S_MUL_NUM: begin
				if (!mul_busy) begin
					div_req.start = 1'b1;
					if (oor_q) begin
						div_req.dividend = DIVIDEND_W'({win_sum_q, 1'b0}) + MEAN_BIAS;
						div_req.divisor  = MEAN_DIV;
					end else begin
						div_req.dividend = mul_prod;
						div_req.divisor  = DIVISOR_W'(den_q);
					end
				end
			end
			S_BAND: begin
				if (raw_oor_c) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIVIDEND_W'({win_sum_q, 1'b0}) + MEAN_BIAS;
					div_req.divisor  = MEAN_DIV;
				end else begin
					mul_req.start = 1'b1;
					mul_req.mcand = mul_prod[NUM_W-1:0];
					mul_req.mplr  = MPLR_W'(band_pct(band_c));
				end
			end
			S_MUL_PCT: begin
				if (!mul_busy) begin
					div_req.start    = 1'b1;
					div_req.dividend = mul_prod;
					div_req.divisor  = den100_c;
				end
			end
			S_DIV_COR: begin
				if (!div_busy) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIVIDEND_W'({win_sum_q, 1'b0}) + MEAN_BIAS;
					div_req.divisor  = MEAN_DIV;
				end
			end
			default: ;
		endcase
	end

	// reading sequencer and output register
	logic              out_valid_q;
	logic [MEAN_W-1:0] out_mean_q;
	logic [RES_W-1:0]  out_res_q;
	logic              out_oor_q;
	logic [BAND_W-1:0] out_band_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			den_q       <= '0;
			held_q      <= '0;
			mean_q      <= '0;
			oor_q       <= 1'b0;
			band_q      <= '0;
			out_valid_q <= 1'b0;
			out_mean_q  <= '0;
			out_res_q   <= '0;
			out_oor_q   <= 1'b0;
			out_band_q  <= '0;
		end else begin
			// a new reading takes the output register, otherwise a taken one frees it
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (readings.valid && readings.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take && last_smp)
						state_q <= S_PREP;
				end
				S_PREP: begin
					den_q   <= scale_c - win_sum_q;
					oor_q   <= den_bad_c;
					band_q  <= '0;
					state_q <= S_MUL_NUM;
				end
				S_MUL_NUM: begin
					if (!mul_busy)
						state_q <= oor_q ? S_DIV_MEAN : S_DIV_RAW;
				end
				S_DIV_RAW: begin
					if (!div_busy)
						state_q <= S_BAND;
				end
				S_BAND: begin
					oor_q   <= raw_oor_c;
					band_q  <= raw_oor_c ? '0 : band_c;
					state_q <= raw_oor_c ? S_DIV_MEAN : S_MUL_PCT;
				end
				S_MUL_PCT: begin
					if (!mul_busy)
						state_q <= S_DIV_COR;
				end
				S_DIV_COR: begin
					if (!div_busy) begin
						held_q  <= div_quo[RES_W-1:0];
						state_q <= S_DIV_MEAN;
					end
				end
				S_DIV_MEAN: begin
					if (!div_busy) begin
						mean_q  <= div_quo[MEAN_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_mean_q  <= mean_q;
						out_res_q   <= held_q;
						out_oor_q   <= oor_q;
						out_band_q  <= band_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign readings.valid           = out_valid_q;
	assign readings.mean_code       = out_mean_q;
	assign readings.resistance_ohms = out_res_q;
	assign readings.out_of_range    = out_oor_q;
	assign readings.band            = out_band_q;

endmodule

// ===== rtl/core/rrm_serial_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
module rrm_serial_mul
	import rrm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mul_req_t          req,
	output logic              busy,
	output logic [PROD_W-1:0] product
);

	localparam logic [MUL_CNT_W-1:0] LAST_STEP = MUL_CNT_W'(MPLR_W - 1);

	logic                 busy_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]    acc_q;
	logic [NUM_W-1:0]     mcand_q;
	logic [MPLR_W-1:0]    mplr_q;
	logic [PROD_W-1:0]    addend;

	// partial product of the current multiplier bit
	assign addend = mplr_q[MPLR_W-1] ? PROD_W'(mcand_q) : '0;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP)
				busy_q <= 1'b0;
		end
	end

	// accumulator and operand shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q   <= '0;
			mcand_q <= req.mcand;
			mplr_q  <= req.mplr;
		end else if (busy_q) begin
			acc_q  <= {acc_q[PROD_W-2:0], 1'b0} + addend;
			mplr_q <= {mplr_q[MPLR_W-2:0], 1'b0};
		end
	end

	assign busy    = busy_q;
	assign product = acc_q;

endmodule

// ===== rtl/core/rrm_serial_div.sv =====
// Restoring divider, one quotient bit per cycle; shared by all divisions of a reading.
`timescale 1ns / 1ps
module rrm_serial_div
	import rrm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_req_t              req,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;   // dividend bits shift out, quotient bits shift in
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// one trial subtraction per cycle
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP)
				busy_q <= 1'b0;
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/rrm_checker.sv =====
// Port-level checks on the reading channel of the resistance meter, bound to the top level.
`timescale 1ns / 1ps
module rrm_checker
	import rrm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              readings_valid,
	input logic              readings_ready,
	input logic [MEAN_W-1:0] mean_code,
	input logic [RES_W-1:0]  resistance_ohms,
	input logic              out_of_range,
	input logic [BAND_W-1:0] band
);

	// a waiting reading stays offered
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		readings_valid && !readings_ready |=> readings_valid)
		else $error("reading withdrawn before it was taken");

	// a waiting reading keeps its payload
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		readings_valid && !readings_ready |=>
		$stable(mean_code) && $stable(resistance_ohms) && $stable(out_of_range)
		&& $stable(band))
		else $error("reading payload changed while stalled");

	// an out-of-range reading reports no band
	a_oor_band: assert property (@(posedge clk) disable iff (!arst_n)
		readings_valid && out_of_range |-> band == '0)
		else $error("band set on an out-of-range reading");

	// corrected value stays within the largest band factor on the upper range edge
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		readings_valid |-> resistance_ohms <= RES_MAX)
		else $error("corrected resistance above its bound");

endmodule

bind ratiometric_resistance_meter_top rrm_checker u_rrm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.readings_valid  (readings.valid),
	.readings_ready  (readings.ready),
	.mean_code       (readings.mean_code),
	.resistance_ohms (readings.resistance_ohms),
	.out_of_range    (readings.out_of_range),
	.band            (readings.band)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the ratiometric resistance meter: windows of samples, readings.
`timescale 1ns / 1ps
module tb;
	import rrm_pkg::*;

	localparam int WIN            = 500;        // samples per reading
	localparam int RANDOM_WINDOWS = 36;
	localparam int SETTLE_CYCLES  = 16;         // quiet time before a register write
	localparam int DRAIN_CYCLES   = 250;        // longest reading latency, with margin
	localparam int CYCLE_LIMIT    = 2000000;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam longint unsigned OHMS_MIN = 485;
	localparam longint unsigned OHMS_MAX = 105000;

	// correction bands, named by their percent factor
	typedef enum logic [BAND_W-1:0] {
		BAND_70, BAND_75, BAND_82, BAND_88, BAND_93, BAND_102, BAND_110
	} band_e;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic [RES_W-1:0]  res;
		logic              oor;
		logic [BAND_W-1:0] band;
	} reading_t;

	// one directed window: register writes, sample pattern, optional typed reading
	typedef struct packed {
		logic                  wr_ref;
		logic [CFG_DATA_W-1:0] ref_data;
		logic                  wr_full;
		logic [CFG_DATA_W-1:0] full_data;
		logic                  wr_spare;
		logic                  mid;
		logic [SAMPLE_W-1:0]   smp_a;
		logic [SAMPLE_W-1:0]   smp_b;
		logic [9:0]            n_a;
		logic                  typed;
		reading_t              want;
	} window_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rrm_sample_if  sm();
	rrm_reading_if rd();
	rrm_cfg_if     cf();

	ratiometric_resistance_meter_top #(
		.SAMPLES_PER_READING(WIN),
		.SAMPLE_BITS(SAMPLE_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sm),
		.readings(rd),
		.cfg(cf)
	);

	// predictor state
	logic [REF_W-1:0]  ref_ohms_q;
	logic [FULL_W-1:0] full_code_q;
	logic [SUM_W-1:0]  acc_sum;
	int unsigned       acc_count;
	logic [RES_W-1:0]  held_res;
	reading_t          pending_readings[$];

	// register writes queued for the next window
	logic                  pend_ref_en, pend_full_en, pend_spare;
	logic [CFG_DATA_W-1:0] pend_ref, pend_full;

	logic        use_typed;
	reading_t    typed_reading;
	logic        calm_tx, calm_rx;
	logic [SAMPLE_W-1:0] win_samples[$];
	window_row_t dir_rows[$];
	int unsigned n_errors = 0;
	int unsigned cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reading for a closed window
	function automatic reading_t predict_reading(input logic [SUM_W-1:0] sum,
		input logic [REF_W-1:0] r_ohms, input logic [FULL_W-1:0] fs,
		input logic [RES_W-1:0] held);
		reading_t rv;
		longint unsigned s, ohms, scale, den, num, raw, pct;
		band_e b;
		s = sum;
		ohms = r_ohms;
		scale = longint'(WIN) * fs;
		rv.mean = MEAN_W'((2 * s + WIN) / (2 * WIN));
		rv.res = held;
		rv.oor = 1'b1;
		rv.band = BAND_70;
		if (scale > s) begin
			den = scale - s;
			num = ohms * s;
			if (num >= OHMS_MIN * den && num <= OHMS_MAX * den) begin
				raw = num / den;
				if (raw < 800) begin
					b = BAND_70; pct = 70;
				end else if (raw < 900) begin
					b = BAND_75; pct = 75;
				end else if (raw < 1500) begin
					b = BAND_82; pct = 82;
				end else if (raw < 2500) begin
					b = BAND_88; pct = 88;
				end else if (raw < 8000) begin
					b = BAND_93; pct = 93;
				end else if (raw < 50000) begin
					b = BAND_102; pct = 102;
				end else begin
					b = BAND_110; pct = 110;
				end
				rv.oor = 1'b0;
				rv.band = b;
				rv.res = RES_W'((num * pct) / (den * 100));
			end
		end
		return rv;
	endfunction

	// one sample item, with a random gap ahead of it
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int unsigned w;
		reading_t r;
		w = calm_tx ? 0 : $urandom_range(0, 11);
		if (w != 0) begin
			sm.valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		sm.valid <= 1'b1;
		sm.sample <= s;
		do @(posedge clk); while (!sm.ready);
		acc_sum = acc_sum + s;
		acc_count++;
		if (acc_count == WIN) begin
			r = predict_reading(acc_sum, ref_ohms_q, full_code_q, held_res);
			held_res = r.res;
			pending_readings.push_back(use_typed ? typed_reading : r);
			acc_sum = '0;
			acc_count = 0;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cf.valid <= 1'b1;
		cf.index <= idx;
		cf.data <= d;
		do @(posedge clk); while (!cf.ready);
		case (idx)
			REG_REFERENCE_OHMS:  ref_ohms_q = d[REF_W-1:0];
			REG_FULL_SCALE_CODE: full_code_q = d[FULL_W-1:0];
			default: ;
		endcase
	endtask

	// hold samples, let every reading drain, then write the queued registers
	task automatic apply_pending();
		if (pend_ref_en || pend_full_en || pend_spare) begin
			sm.valid <= 1'b0;
			while (pending_readings.size() != 0) @(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
			if (pend_ref_en)  write_reg(REG_REFERENCE_OHMS, pend_ref);
			if (pend_full_en) write_reg(REG_FULL_SCALE_CODE, pend_full);
			if (pend_spare) begin
				write_reg(REG_SPARE_A, 20'hFFFFF);
				write_reg(REG_SPARE_B, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
			end
			cf.valid <= 1'b0;
		end
	endtask

	// send win_samples; queued writes go before the window or half way through it
	task automatic play_window(input logic mid);
		if (!mid) apply_pending();
		for (int i = 0; i < WIN; i++) begin
			if (mid && i == WIN / 2) apply_pending();
			send_sample(win_samples[i]);
		end
		win_samples.delete();
	endtask

	task automatic add_row(input logic wr_ref, input logic [CFG_DATA_W-1:0] ref_data,
		input logic wr_full, input logic [CFG_DATA_W-1:0] full_data, input logic wr_spare,
		input logic mid, input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
		input int n_a, input logic typed, input reading_t want);
		window_row_t row;
		row.wr_ref = wr_ref;
		row.ref_data = ref_data;
		row.wr_full = wr_full;
		row.full_data = full_data;
		row.wr_spare = wr_spare;
		row.mid = mid;
		row.smp_a = a;
		row.smp_b = b;
		row.n_a = 10'(n_a);
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	// reading sink: random stall before each item, with calm stretches
	initial begin : drain_readings
		int unsigned w;
		rd.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			w = calm_rx ? 0 : $urandom_range(0, 11);
			if (w != 0) begin
				rd.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			rd.ready <= 1'b1;
			do @(posedge clk); while (!(rd.valid && rd.ready));
		end
	end

	// compare each taken reading with the oldest expectation
	always @(posedge clk) begin : check_readings
		reading_t want, got;
		if (arst_n && rd.valid && rd.ready) begin
			got = {rd.mean_code, rd.resistance_ohms, rd.out_of_range, rd.band};
			if (pending_readings.size() == 0) begin
				n_errors++;
				$display("%0t unexpected reading: expected none, got mean %0d res %0d oor %0d band %0d",
					$time, got.mean, got.res, got.oor, got.band);
			end else begin
				want = pending_readings.pop_front();
				if (got !== want) begin
					n_errors++;
					$display("%0t reading mismatch: expected mean %0d res %0d oor %0d band %0d, got mean %0d res %0d oor %0d band %0d",
						$time, want.mean, want.res, want.oor, want.band,
						got.mean, got.res, got.oor, got.band);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[ratiometric_resistance_meter_top] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		window_row_t r;
		int unsigned mode, j, tgt_lo, tgt_hi;
		longint unsigned tgt, centre, eff_ref, eff_full;
		int c;
		sm.valid <= 1'b0;
		sm.sample <= '0;
		cf.valid <= 1'b0;
		cf.index <= REG_REFERENCE_OHMS;
		cf.data <= '0;
		ref_ohms_q = REF_RESET;
		full_code_q = FULL_RESET;
		acc_sum = '0;
		acc_count = 0;
		held_res = '0;
		use_typed = 1'b0;
		typed_reading = '0;
		calm_tx = 1'b0;
		calm_rx = 1'b0;
		pend_ref_en = 1'b0;
		pend_full_en = 1'b0;
		pend_spare = 1'b0;
		pend_ref = '0;
		pend_full = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed windows: reset values, range edges, every band, bad denominators
		add_row(0, 0, 0, 0, 0, 0, 12'd0, 12'd0, WIN, 1, {12'd0, 17'd0, 1'b1, BAND_70});
		add_row(0, 0, 0, 0, 0, 0, 12'd4095, 12'd0, WIN, 1, {12'd4095, 17'd0, 1'b1, BAND_70});
		add_row(0, 0, 0, 0, 0, 0, 12'd2047, 12'd2048, WIN / 2, 0, '0);  // mean rounds half up
		add_row(0, 0, 0, 0, 0, 0, 12'd50, 12'd0, WIN, 0, '0);
		add_row(0, 0, 0, 0, 0, 0, 12'd70, 12'd0, WIN, 0, '0);
		add_row(0, 0, 0, 0, 0, 0, 12'd100, 12'd0, WIN, 0, '0);
		add_row(0, 0, 0, 0, 0, 0, 12'd160, 12'd0, WIN, 0, '0);
		add_row(0, 0, 0, 0, 0, 0, 12'd400, 12'd0, WIN, 0, '0);
		add_row(0, 0, 0, 0, 0, 0, 12'd2800, 12'd0, WIN, 0, '0);
		add_row(0, 0, 0, 0, 0, 0, 12'd2900, 12'd0, WIN, 0, '0);       // raw above range
		add_row(0, 0, 0, 0, 0, 0, 12'd40, 12'd0, WIN, 0, '0);         // raw below range
		add_row(1, 20'd485, 1, 20'hAB7D0, 0, 0, 12'd1000, 12'd0, WIN, 1,
			{12'd1000, 17'd339, 1'b0, BAND_70});
		add_row(1, 20'd800, 0, 0, 0, 0, 12'd1000, 12'd0, WIN, 1,
			{12'd1000, 17'd600, 1'b0, BAND_75});
		add_row(1, 20'd105000, 0, 0, 0, 0, 12'd1000, 12'd0, WIN, 1,
			{12'd1000, 17'd115500, 1'b0, BAND_110});
		add_row(1, 20'd105001, 0, 0, 0, 0, 12'd1000, 12'd0, WIN, 1,
			{12'd1000, 17'd115500, 1'b1, BAND_70});
		add_row(1, 20'd0, 0, 0, 0, 0, 12'd1000, 12'd0, WIN, 1,
			{12'd1000, 17'd115500, 1'b1, BAND_70});
		add_row(1, 20'd1000000, 1, 20'hFF000, 0, 0, 12'd3000, 12'd0, WIN, 1,
			{12'd3000, 17'd115500, 1'b1, BAND_70});
		add_row(0, 0, 1, 20'd1000, 0, 1, 12'd2000, 12'd0, WIN, 1,
			{12'd2000, 17'd115500, 1'b1, BAND_70});
		add_row(1, 20'd47000, 1, 20'd4095, 0, 1, 12'd2048, 12'd0, WIN, 0, '0);
		add_row(0, 0, 0, 0, 1, 0, 12'd400, 12'd0, WIN, 0, '0);        // spare indexes ignored

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			pend_ref_en = r.wr_ref;
			pend_ref = r.ref_data;
			pend_full_en = r.wr_full;
			pend_full = r.full_data;
			pend_spare = r.wr_spare;
			use_typed = r.typed;
			typed_reading = r.want;
			calm_tx = ($urandom_range(0, 3) == 0);
			calm_rx = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < WIN; k++)
				win_samples.push_back((k < r.n_a) ? r.smp_a : r.smp_b);
			play_window(r.mid);
		end
		use_typed = 1'b0;

		// random windows, mostly aimed at a chosen raw resistance
		for (int k = 0; k < RANDOM_WINDOWS; k++) begin
			pend_spare = 1'b0;
			pend_ref_en = (k % 3 == 0);
			pend_full_en = (k % 3 == 0);
			if (k % 3 == 0) begin
				case ($urandom_range(0, 5))
					0: pend_ref = 20'd1;
					1: pend_ref = 20'd1000000;
					2: pend_ref = 20'hFFFFF;
					default: pend_ref = CFG_DATA_W'($urandom_range(1, 1000000));
				endcase
				case ($urandom_range(0, 5))
					0: pend_full = 20'd4095;
					1: pend_full = 20'd1;
					2: pend_full = CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
					default: pend_full = CFG_DATA_W'(($urandom_range(0, 255) << 12)
						| $urandom_range(1024, 4095));
				endcase
			end
			eff_ref = pend_ref_en ? pend_ref[REF_W-1:0] : ref_ohms_q;
			eff_full = pend_full_en ? pend_full[FULL_W-1:0] : full_code_q;
			calm_tx = ($urandom_range(0, 3) == 0);
			calm_rx = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 9);
			if (mode < 2) begin
				// noise
				for (int i = 0; i < WIN; i++)
					win_samples.push_back(SAMPLE_W'($urandom_range(0, 4095)));
			end else begin
				case ($urandom_range(0, 8))
					0: begin tgt_lo = 100;    tgt_hi = 484;    end
					1: begin tgt_lo = 485;    tgt_hi = 799;    end
					2: begin tgt_lo = 800;    tgt_hi = 899;    end
					3: begin tgt_lo = 900;    tgt_hi = 1499;   end
					4: begin tgt_lo = 1500;   tgt_hi = 2499;   end
					5: begin tgt_lo = 2500;   tgt_hi = 7999;   end
					6: begin tgt_lo = 8000;   tgt_hi = 49999;  end
					7: begin tgt_lo = 50000;  tgt_hi = 105000; end
					default: begin tgt_lo = 105001; tgt_hi = 400000; end
				endcase
				tgt = $urandom_range(tgt_lo, tgt_hi);
				centre = (eff_full * tgt) / (eff_ref + tgt);
				j = $urandom_range(0, 3);
				for (int i = 0; i < WIN; i++) begin
					c = int'(centre) + int'($urandom_range(0, 2 * j)) - int'(j);
					if (c < 0) c = 0;
					if (c > 4095) c = 4095;
					win_samples.push_back(SAMPLE_W'(c));
				end
			end
			play_window(k % 6 == 3);
		end

		// drain and finish
		sm.valid <= 1'b0;
		calm_rx = 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && pending_readings.size() == 0) begin
			$display("[ratiometric_resistance_meter_top] OK");
		end else begin
			$display("%0t %0d readings still expected", $time, pending_readings.size());
			$display("[ratiometric_resistance_meter_top] ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rrm_pkg.sv
rtl/core/rrm_if.sv
rtl/core/rrm_serial_mul.sv
rtl/core/rrm_serial_div.sv
rtl/core/ratiometric_resistance_meter_top.sv
rtl/core/rrm_checker.sv
verif/tb.sv
